// ===== hdl/lfhp_pkg.sv =====
// shared codes and result type for the led frame header parser
`timescale 1ns / 1ps

package lfhp_pkg;

  localparam int DEF_MAX_LEDS = 1024;
  localparam int LED_CNT_W    = 11;
  localparam int BYTE_W       = 8;
  localparam int STATUS_W     = 3;
  localparam int INDEX_W      = 12;
  localparam int PHASE_W      = 3;
  localparam int END_W        = 18;

  localparam logic [LED_CNT_W-1:0] LED_COUNT_RST = 11'd1024;

  localparam logic [BYTE_W-1:0] HDR_A   = 8'h41;
  localparam logic [BYTE_W-1:0] HDR_D   = 8'h64;
  localparam logic [BYTE_W-1:0] HDR_A2  = 8'h61;
  localparam logic [BYTE_W-1:0] CSUM_XOR = 8'h55;

  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PROGRESS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACCEPT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd5;

  localparam logic [2:0] REG_LED_COUNT = 3'd0;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                color_write;
    logic [INDEX_W-1:0]  color_addr;
    logic [BYTE_W-1:0]   color_value;
    logic                frame_done;
  } lfhp_result_t;

endpackage

// ===== hdl/lfhp_core.sv =====
// parser state and per-byte next-state and result logic
`timescale 1ns / 1ps

module lfhp_core #(
  parameter int MAX_LEDS = lfhp_pkg::DEF_MAX_LEDS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [lfhp_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [lfhp_pkg::LED_CNT_W-1:0] led_count,
  output lfhp_pkg::lfhp_result_t         result
);
  import lfhp_pkg::*;

  localparam int POS_W = $clog2(3 * MAX_LEDS + 1);
  localparam logic [END_W-1:0] MAX_END = END_W'(MAX_LEDS);

  localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_GOT_A = 3'd1;
  localparam logic [PHASE_W-1:0] PH_GOT_D = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HIGH  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LOW   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CHECK = 3'd5;
  localparam logic [PHASE_W-1:0] PH_COLOR = 3'd6;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BYTE_W-1:0]  count_high_r, count_high_nxt;
  logic [BYTE_W-1:0]  count_low_r, count_low_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  logic [END_W-1:0]         lc_ext, lc_clamp, frame_end, pos_inc_ext;
  logic                     lc_ok, hdr_ok;
  logic [POS_W-1:0]         pos_inc;
  logic [POS_W+INDEX_W-1:0] pos_wide;
  logic [LED_CNT_W-1:0]     lc_m1;

  always_comb begin
    lc_ext = END_W'(led_count);
    lc_ok  = (led_count != '0) && (lc_ext <= MAX_END);
    if (led_count == '0) begin
      lc_clamp = END_W'(1);
    end else if (lc_ext > MAX_END) begin
      lc_clamp = MAX_END;
    end else begin
      lc_clamp = lc_ext;
    end
    frame_end   = lc_clamp + (lc_clamp << 1);
    pos_inc     = pos_r + POS_W'(1);
    pos_inc_ext = END_W'(pos_inc);
    pos_wide    = {{INDEX_W{1'b0}}, pos_r};
    lc_m1       = led_count - LED_CNT_W'(1);
    hdr_ok      = (rx_byte == (count_high_r ^ count_low_r ^ CSUM_XOR)) && lc_ok &&
                  ({count_high_r, count_low_r} == 16'(lc_m1));
  end

  always_comb begin
    phase_nxt      = phase_r;
    count_high_nxt = count_high_r;
    count_low_nxt  = count_low_r;
    pos_nxt        = pos_r;
    result         = '0;
    case (phase_r)
      PH_GOT_A: begin
        if (rx_byte == HDR_D) begin
          phase_nxt     = PH_GOT_D;
          result.status = ST_PROGRESS;
        end else begin
          phase_nxt     = PH_HUNT;
          result.status = ST_REJECT;
        end
      end
      PH_GOT_D: begin
        if (rx_byte == HDR_A2) begin
          phase_nxt     = PH_HIGH;
          result.status = ST_PROGRESS;
        end else begin
          phase_nxt     = PH_HUNT;
          result.status = ST_REJECT;
        end
      end
      PH_HIGH: begin
        count_high_nxt = rx_byte;
        phase_nxt      = PH_LOW;
        result.status  = ST_PROGRESS;
      end
      PH_LOW: begin
        count_low_nxt = rx_byte;
        phase_nxt     = PH_CHECK;
        result.status = ST_PROGRESS;
      end
      PH_CHECK: begin
        if (hdr_ok) begin
          pos_nxt       = '0;
          phase_nxt     = PH_COLOR;
          result.status = ST_ACCEPT;
        end else begin
          phase_nxt     = PH_HUNT;
          result.status = ST_REJECT;
        end
      end
      PH_COLOR: begin
        result.color_write = 1'b1;
        result.color_addr  = pos_wide[INDEX_W-1:0];
        result.color_value = rx_byte;
        pos_nxt            = pos_inc;
        if (pos_inc_ext >= frame_end) begin
          result.frame_done = 1'b1;
          result.status     = ST_DONE;
          phase_nxt         = PH_HUNT;
        end else begin
          result.status = ST_STORED;
        end
      end
      default: begin
        if (rx_byte == HDR_A) begin
          phase_nxt     = PH_GOT_A;
          result.status = ST_PROGRESS;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      count_high_r <= '0;
      count_low_r  <= '0;
      pos_r        <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      count_high_r <= count_high_nxt;
      count_low_r  <= count_low_nxt;
      pos_r        <= pos_nxt;
    end
  end

  // position never runs past the end of the largest frame
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    END_W'(pos_r) <= MAX_END + (MAX_END << 1))
    else $error("colour position out of range");

  // a frame starts at position zero
  a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_CHECK && hdr_ok |=> pos_r == '0 && phase_r == PH_COLOR)
    else $error("accepted header did not start a frame");

  // the hunt is resumed after the last colour byte
  a_done_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.frame_done |=> phase_r == PH_HUNT)
    else $error("frame end did not return to hunt");

endmodule

// ===== hdl/led_frame_header_parser_top.sv =====
// top level: input register, parser core, result register and config register
`timescale 1ns / 1ps

//  channel | ports                                         | role
//  in      | in_valid, in_ready, in_rx_byte                 | serial bytes in
//  out     | out_valid, out_ready, out_status, out_color_*, | one result per byte
//          | out_frame_done                                 |
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata,  | led_count register
//          | pready                                         |
// one byte per cycle sustained while out_ready stays high; a byte passes the input reg, then the result reg
// parser state updates when a byte moves from the input reg into the result reg
// synchronous active-low reset returns to the header hunt, led_count to 1024
// a stalled result holds the input reg, which then drops in_ready

module led_frame_header_parser_top #(
  parameter int MAX_LEDS = lfhp_pkg::DEF_MAX_LEDS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lfhp_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lfhp_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_color_write,
  output logic [lfhp_pkg::INDEX_W-1:0]     out_color_addr,
  output logic [lfhp_pkg::BYTE_W-1:0]      out_color_value,
  output logic                             out_frame_done,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lfhp_pkg::*;

  logic [LED_CNT_W-1:0] led_count_r;
  logic                 s1_valid_r;
  logic [BYTE_W-1:0]    s1_byte_r;
  logic                 out_valid_r;
  lfhp_result_t         res, out_r;
  logic                 step;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_LED_COUNT) ? {{(32-LED_CNT_W){1'b0}}, led_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= LED_COUNT_RST;
    end else if (psel && penable && pwrite && paddr == REG_LED_COUNT) begin
      led_count_r <= pwdata[LED_CNT_W-1:0];
    end
  end

  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  lfhp_core #(
    .MAX_LEDS (MAX_LEDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (s1_byte_r),
    .led_count (led_count_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_color_write = out_r.color_write;
  assign out_color_addr  = out_r.color_addr;
  assign out_color_value = out_r.color_value;
  assign out_frame_done  = out_r.frame_done;

  // colour writes go with stored or done status only
  a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_color_write == (out_status == ST_STORED || out_status == ST_DONE))
    else $error("color_write disagrees with status");

  // frame end is flagged only with the done status
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_done == (out_status == ST_DONE))
    else $error("frame_done disagrees with status");

  // non-colour results carry zero address and value
  a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_color_write |-> out_color_addr == '0 && out_color_value == '0)
    else $error("payload set on a non-colour item");

  // a held input item blocks the input while the result is stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is full");

endmodule

// ===== tb/led_frame_header_parser_top_test.sv =====
// self-checking testbench for the led frame header parser top level
`timescale 1ns / 1ps

module led_frame_header_parser_top_test;
  import lfhp_pkg::*;

  localparam int MAX_LEDS = DEF_MAX_LEDS;
  localparam logic [2:0] LED_COUNT_ADDR = 3'(4 * REG_LED_COUNT);
  localparam int OPEN_FRAME_BYTES = 192;
  localparam int TOTAL_ITEMS = 1050;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_GOT_A,
    PH_GOT_D,
    PH_HIGH,
    PH_LOW,
    PH_CHECK,
    PH_COLOR
  } parse_phase_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_color_write;
  logic [INDEX_W-1:0]  out_color_addr;
  logic [BYTE_W-1:0]   out_color_value;
  logic                out_frame_done;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state
  logic [LED_CNT_W-1:0] led_count_cfg = LED_COUNT_RST;
  parse_phase_t         parse_phase = PH_HUNT;
  logic [7:0]           count_hi = '0;
  logic [7:0]           count_lo = '0;
  logic [15:0]          byte_pos = '0;

  lfhp_result_t predicted_results[$];
  lfhp_result_t want_result;
  int unsigned  bytes_sent = 0;
  int unsigned  error_count = 0;
  bit           calm = 1'b0;

  led_frame_header_parser_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_color_write (out_color_write),
    .out_color_addr  (out_color_addr),
    .out_color_value (out_color_value),
    .out_frame_done  (out_frame_done),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic lfhp_result_t parse_byte(input logic [7:0] rx);
    lfhp_result_t r;
    int           frame_end;
    int           leds;
    r = '0;
    r.status = ST_IGNORED;
    case (parse_phase)
      PH_GOT_A: begin
        if (rx == HDR_D) begin
          parse_phase = PH_GOT_D;
          r.status = ST_PROGRESS;
        end else begin
          parse_phase = PH_HUNT;
          r.status = ST_REJECT;
        end
      end
      PH_GOT_D: begin
        if (rx == HDR_A2) begin
          parse_phase = PH_HIGH;
          r.status = ST_PROGRESS;
        end else begin
          parse_phase = PH_HUNT;
          r.status = ST_REJECT;
        end
      end
      PH_HIGH: begin
        count_hi = rx;
        parse_phase = PH_LOW;
        r.status = ST_PROGRESS;
      end
      PH_LOW: begin
        count_lo = rx;
        parse_phase = PH_CHECK;
        r.status = ST_PROGRESS;
      end
      PH_CHECK: begin
        if ((count_hi ^ count_lo ^ CSUM_XOR) == rx && led_count_cfg >= 1 &&
            int'(led_count_cfg) <= MAX_LEDS &&
            int'({count_hi, count_lo}) == int'(led_count_cfg) - 1) begin
          byte_pos = '0;
          parse_phase = PH_COLOR;
          r.status = ST_ACCEPT;
        end else begin
          parse_phase = PH_HUNT;
          r.status = ST_REJECT;
        end
      end
      PH_COLOR: begin
        leds = int'(led_count_cfg);
        if (leds < 1) leds = 1;
        if (leds > MAX_LEDS) leds = MAX_LEDS;
        frame_end = 3 * leds;
        r.color_write = 1'b1;
        r.color_addr = byte_pos[INDEX_W-1:0];
        r.color_value = rx;
        byte_pos = byte_pos + 16'd1;
        if (int'(byte_pos) >= frame_end) begin
          r.frame_done = 1'b1;
          r.status = ST_DONE;
          parse_phase = PH_HUNT;
        end else begin
          r.status = ST_STORED;
        end
      end
      default: begin
        parse_phase = PH_HUNT;
        if (rx == HDR_A) begin
          parse_phase = PH_GOT_A;
          r.status = ST_PROGRESS;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected item, status", out_status, 0);
      end else begin
        want_result = predicted_results.pop_front();
        if (out_status !== want_result.status)
          report_mismatch("status", out_status, want_result.status);
        if (out_color_write !== want_result.color_write)
          report_mismatch("color_write", out_color_write, want_result.color_write);
        if (out_color_addr !== want_result.color_addr)
          report_mismatch("color_addr", out_color_addr, want_result.color_addr);
        if (out_color_value !== want_result.color_value)
          report_mismatch("color_value", out_color_value, want_result.color_value);
        if (out_frame_done !== want_result.frame_done)
          report_mismatch("frame_done", out_frame_done, want_result.frame_done);
      end
    end
  end

  // result side backpressure
  initial begin
    forever begin
      @(posedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  task automatic send_byte(input logic [7:0] value);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_results.push_back(parse_byte(value));
    bytes_sent++;
  endtask

  task automatic send_header(input logic [15:0] declared, input logic [7:0] csum_flip);
    send_byte(HDR_A);
    send_byte(HDR_D);
    send_byte(HDR_A2);
    send_byte(declared[15:8]);
    send_byte(declared[7:0]);
    send_byte(declared[15:8] ^ declared[7:0] ^ CSUM_XOR ^ csum_flip);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // leaves psel high so a second transfer can follow back to back
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LED_COUNT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  task automatic check_led_count();
    logic [31:0] rd;
    apb_access(1'b0, 32'h0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[LED_CNT_W-1:0] !== led_count_cfg)
      report_mismatch("led_count readback", rd[LED_CNT_W-1:0], led_count_cfg);
  endtask

  task automatic set_led_count(input logic [LED_CNT_W-1:0] value);
    logic [31:0] rd;
    logic [31:0] wdata;
    wait_idle();
    wdata = $urandom;
    wdata[LED_CNT_W-1:0] = value;
    apb_access(1'b1, wdata, rd);
    led_count_cfg = value;
    check_led_count();
  endtask

  task automatic send_frame();
    int unsigned n_colors;
    if (led_count_cfg >= 1 && int'(led_count_cfg) <= MAX_LEDS)
      n_colors = 3 * led_count_cfg;
    else
      n_colors = $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
    send_header(16'(led_count_cfg) - 16'd1, 8'h00);
    repeat (n_colors) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_broken_header();
    logic [7:0] wrong;
    case ($urandom_range(0, 3))
      0: begin
        do wrong = 8'($urandom_range(0, 255)); while (wrong == HDR_D);
        send_byte(HDR_A);
        send_byte(wrong);
      end
      1: begin
        do wrong = 8'($urandom_range(0, 255)); while (wrong == HDR_A2);
        send_byte(HDR_A);
        send_byte(HDR_D);
        send_byte(wrong);
      end
      2: send_header(16'(led_count_cfg) - 16'd1, 8'($urandom_range(1, 255)));
      default: send_header(16'(led_count_cfg) - 16'd1 + 16'($urandom_range(1, 65535)), 8'h00);
    endcase
  endtask

  // header at the reset count, frame left open for the next count change to close
  task automatic test_full_frame_at_reset_count();
    check_led_count();
    calm = 1'b1;
    send_header(16'(MAX_LEDS - 1), 8'h00);
    repeat (OPEN_FRAME_BYTES) send_byte(8'($urandom_range(0, 255)));
    wait_idle();
    calm = 1'b0;
  endtask

  task automatic test_header_errors();
    set_led_count(11'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    // a second 'A' is rejected, not taken as a fresh start
    send_byte(HDR_A);
    send_byte(HDR_A);
    send_byte(HDR_A);
    send_byte(HDR_D);
    send_byte(HDR_D);
    send_header(16'd1, 8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'hFE);
    wait_idle();
  endtask

  task automatic test_invalid_led_count();
    set_led_count(11'd0);
    send_header(16'hFFFF, 8'h00);
    send_header(16'h0000, 8'h00);
    set_led_count(11'd2047);
    send_header(16'd2046, 8'h00);
    set_led_count(11'(MAX_LEDS + 1));
    send_header(16'(MAX_LEDS), 8'h00);
    set_led_count(11'd3);
    send_header(16'd2, 8'h01);
    send_header(16'd3, 8'h00);
    wait_idle();
  endtask

  task automatic test_count_change_mid_frame();
    set_led_count(11'd4);
    send_header(16'd3, 8'h00);
    repeat (8) send_byte(8'($urandom_range(0, 255)));
    // position already past the new end: next byte closes the frame
    set_led_count(11'd1);
    send_byte(8'($urandom_range(0, 255)));
    set_led_count(11'd5);
    send_header(16'd4, 8'h00);
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    set_led_count(11'd2047);
    repeat (5) send_byte(8'($urandom_range(0, 255)));
    set_led_count(11'd3);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned          stop_at;
    int unsigned          segment;
    int unsigned          pick;
    logic [LED_CNT_W-1:0] n_leds;
    stop_at = TOTAL_ITEMS;
    segment = 0;
    while (bytes_sent < stop_at) begin
      if (segment % 4 == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) n_leds = 11'($urandom_range(1, 6));
        else if (pick < 92) n_leds = 11'($urandom_range(7, 40));
        else if (pick < 95) n_leds = 11'd0;
        else n_leds = 11'($urandom_range(MAX_LEDS + 1, 2047));
        set_led_count(n_leds);
      end
      calm = (segment >= 12 && segment < 24);
      pick = $urandom_range(0, 99);
      if (pick < 70) send_frame();
      else if (pick < 88) send_broken_header();
      else repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
      segment++;
    end
    calm = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_full_frame_at_reset_count();
    test_header_errors();
    test_invalid_led_count();
    test_count_change_mid_frame();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lfhp_pkg.sv
hdl/lfhp_core.sv
hdl/led_frame_header_parser_top.sv
tb/led_frame_header_parser_top_test.sv
